@@ hdl/rme_pkg.sv @@
package rme_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 16;
  localparam int ANG_FRAC         = 29;
  localparam int AW               = 34;  // angle accumulator width
  localparam int CW               = 58;  // CORDIC x/y width, covers 2^17 growth at the default DATA_WIDTH
  localparam int SQW              = 32;  // radicand width
  localparam int SRW              = 17;  // root width
  localparam int OUT_SHIFT        = ANG_FRAC - 13;
  localparam logic signed [AW-1:0] HALF_PI_UNITS = 34'sd843314857;
  localparam logic signed [15:0] FULL_LIMIT = 16'sd25736;
  localparam logic signed [15:0] HALF_LIMIT = 16'sd12868;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_lut(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0: v = 34'sd421657428;  1: v = 34'sd248918915;  2: v = 34'sd131521918;
      3: v = 34'sd66762579;   4: v = 34'sd33510843;   5: v = 34'sd16771758;
      6: v = 34'sd8387925;    7: v = 34'sd4194219;    8: v = 34'sd2097141;
      9: v = 34'sd1048575;
      default: begin
        if (i < 30) v = AW'(64'sd1 <<< (29 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

@@ hdl/rotation_matrix_to_euler_core.sv @@
// Channel | Dir | Payload (low bit up)
// in_     | in  | tdata: r00,r10,r11,r12,r20,r21,r22 (7 x 16 bit signed Q2.14)
// out_    | out | tdata: roll(16),pitch(15),yaw(16) Q3.13, pad(1); tuser: singular
// cfg_    | in  | wdata: singular_threshold (11 bit Q2.14)
//
// One beat per cycle while no stall holds the pipeline. The pipe is 17 sqrt stages plus CORDIC_STEPS+1 CORDIC stages.
// The sqrt pipeline is 16 bit stages deep; the three atan2 run in parallel pipes.
// Reset clears only valid bits and the threshold (to 1).
// A stall freezes the whole pipeline through one shared enable; nothing is lost.
module rotation_matrix_to_euler_core #(
  parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF,
  parameter int DATA_WIDTH   = rme_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // r00,r10,r11,r12,r20,r21,r22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // roll, pitch, yaw, zero pad
  output logic         out_tuser,  // singular
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata
);
  import rme_pkg::*;

  localparam int SQ_LAT = SQW / 2 + 1;
  localparam int LAT    = SQ_LAT + CORDIC_STEPS + 1;

  logic [10:0] thr_r;
  logic [LAT-1:0] vld_r;
  logic en;

  // pipeline advances unless the last stage holds a beat nobody takes
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 11'd1;
      vld_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  logic signed [15:0] r00, r10, r11, r12, r20, r21, r22;
  assign r00 = in_tdata[15:0];   assign r10 = in_tdata[31:16];
  assign r11 = in_tdata[47:32];  assign r12 = in_tdata[63:48];
  assign r20 = in_tdata[79:64];  assign r21 = in_tdata[95:80];
  assign r22 = in_tdata[111:96];

  logic [SQW-1:0] sum;
  logic signed [31:0] p0, p1;
  assign p0  = r00 * r00;
  assign p1  = r10 * r10;
  assign sum = SQW'(p0) + SQW'(p1);

  logic [SRW-1:0] sy;
  rme_sqrt u_sqrt (.clk(clk), .en(en), .n_in(sum), .root(sy));

  // delay the operands alongside the root
  typedef struct packed {
    logic signed [15:0] r00, r10, r11, r12, r20, r21, r22;
  } elem_t;
  elem_t dl_r [SQ_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= '{r00, r10, r11, r12, r20, r21, r22};
      for (int k = 1; k < SQ_LAT; k++) dl_r[k] <= dl_r[k-1];
    end
  end

  elem_t e;
  logic sing;
  assign e    = dl_r[SQ_LAT-1];
  assign sing = {1'b0, sy} < (SRW+1)'(thr_r);

  logic signed [17:0] ry, rx, py, px, yy, yx;
  always_comb begin
    py = -18'(e.r20);  px = 18'(sy);
    yy = 18'(e.r10);   yx = 18'(e.r00);
    if (sing) begin
      ry = -18'(e.r12); rx = 18'(e.r11);
    end else begin
      ry = 18'(e.r21);  rx = 18'(e.r22);
    end
  end

  logic signed [15:0] roll, pitch, yaw;
  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_roll
    (.clk(clk), .en(en), .y_in(ry), .x_in(rx), .lim(FULL_LIMIT), .ang(roll));
  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_pitch
    (.clk(clk), .en(en), .y_in(py), .x_in(px), .lim(HALF_LIMIT), .ang(pitch));
  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_yaw
    (.clk(clk), .en(en), .y_in(yy), .x_in(yx), .lim(FULL_LIMIT), .ang(yaw));

  // carry the branch flag down the CORDIC depth
  logic [CORDIC_STEPS:0] sg_r;
  always_ff @(posedge clk) begin
    if (en) sg_r <= {sg_r[CORDIC_STEPS-1:0], sing};
  end

  assign out_tuser = sg_r[CORDIC_STEPS];
  assign out_tdata = {1'b0, sg_r[CORDIC_STEPS] ? 16'd0 : yaw, pitch[14:0], roll};
endmodule

@@ hdl/rme_cordic.sv @@
module rme_cordic #(
  parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF,
  parameter int DATA_WIDTH   = rme_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [17:0]              y_in,
  input  logic signed [17:0]              x_in,
  input  logic signed [15:0]              lim,
  output logic signed [15:0]              ang
);
  import rme_pkg::*;

  cordic_t st_r [CORDIC_STEPS+1];
  logic signed [15:0] lim_r [CORDIC_STEPS+1];
  cordic_t pre;
  logic signed [CW-1:0] xs, ys;
  logic signed [AW-1:0] zr, zs;

  always_comb begin
    xs = CW'(x_in) <<< DATA_WIDTH;
    ys = CW'(y_in) <<< DATA_WIDTH;
    pre.zero = (x_in == 0) && (y_in == 0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        pre.x = ys; pre.y = -xs; pre.z = HALF_PI_UNITS;
      end else begin
        pre.x = -ys; pre.y = xs; pre.z = -HALF_PI_UNITS;
      end
    end else begin
      pre.x = xs; pre.y = ys; pre.z = '0;
    end
  end

  // stage 0 holds the pre-rotation, stage i+1 the result of iteration i
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= pre;
      lim_r[0] <= lim;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    localparam int SH = (i < 32) ? i : 31;
    cordic_t s, n;
    always_comb begin
      s = st_r[i];
      n = s;
      if (i < 32) begin
        if (s.y >= 0) begin
          n.x = s.x + (s.y >>> SH); n.y = s.y - (s.x >>> SH); n.z = s.z + atan_lut(i);
        end else begin
          n.x = s.x - (s.y >>> SH); n.y = s.y + (s.x >>> SH); n.z = s.z - atan_lut(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1]  <= n;
        lim_r[i+1] <= lim_r[i];
      end
    end
  end

  always_comb begin
    zr = (st_r[CORDIC_STEPS].z + (AW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    zs = AW'(lim_r[CORDIC_STEPS]);
    if (st_r[CORDIC_STEPS].zero) ang = '0;
    else if (zr > zs) ang = lim_r[CORDIC_STEPS];
    else if (zr < -zs) ang = -lim_r[CORDIC_STEPS];
    else ang = zr[15:0];
  end
endmodule

@@ hdl/rme_sqrt.sv @@
module rme_sqrt (
  input  logic                  clk,
  input  logic                  en,
  input  logic [rme_pkg::SQW-1:0] n_in,
  output logic [rme_pkg::SRW-1:0] root
);
  import rme_pkg::*;

  localparam int NS = SQW / 2;
  logic [SQW-1:0] rem_r [NS+1];
  logic [SRW-1:0] q_r   [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_in;
      q_r[0]   <= '0;
    end
  end

  // one result bit per stage, trial-squaring method
  for (genvar i = 0; i < NS; i++) begin : g_bit
    localparam int B = NS - 1 - i;
    logic [SQW+1:0] trial;
    logic [SRW-1:0] qn;
    always_comb begin
      qn    = q_r[i] | (SRW'(1) << B);
      trial = (SQW+2)'(qn) * (SQW+2)'(qn);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_r[i];
        q_r[i+1]   <= (trial <= (SQW+2)'(rem_r[i])) ? qn : q_r[i];
      end
    end
  end

  assign root = q_r[NS];
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns/1ps
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  // Predictor step count and fraction bits, random beat count and watchdog limit.
  localparam int NSTEPS   = 16;
  localparam int FRACBITS = 16;
  localparam int N_RAND   = 1030;
  localparam int DOG_MAX  = 5000;

  typedef struct packed {
    logic signed [15:0] r22, r21, r20, r12, r11, r10, r00;
  } matrix_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sing;
  } euler_t;

  // One row of the directed table: matrix, threshold to load first (-1 keeps it),
  // and an optional typed expectation (use_typed) for rows read off at a glance.
  typedef struct {
    matrix_t m;
    int      thr;
    bit      use_typed;
    euler_t  typed;
  } row_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 0;
  logic [10:0]  cfg_wdata = '0;

  rotation_matrix_to_euler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Predictor copy of the threshold register.
  logic [10:0] thr_shadow = 11'd1;
  euler_t      angle_queue[$];
  int          fail_cnt = 0;
  int          stall_cnt = 0;

  function automatic longint tab_atan(int i);
    case (i)
      0: return 421657428;  1: return 248918915;  2: return 131521918;
      3: return 66762579;   4: return 33510843;   5: return 16771758;
      6: return 8387925;    7: return 4194219;    8: return 2097141;
      9: return 1048575;
      default: return (i < 30) ? (64'sd1 <<< (29 - i)) : 0;
    endcase
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Vectoring CORDIC with quarter-turn pre-rotation for x < 0.
  function automatic longint vector_angle(longint y_in, longint x_in, longint lim);
    longint x, y, z, t, xs, ys;
    x = x_in <<< FRACBITS;
    y = y_in <<< FRACBITS;
    z = 0;
    if (x_in == 0 && y_in == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 843314857;
      end else begin
        t = x; x = -y; y = t; z = -843314857;
      end
    end
    for (int i = 0; i < NSTEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += tab_atan(i);
      end else begin
        x -= ys; y += xs; z -= tab_atan(i);
      end
    end
    return sat((z + 64'sd32768) >>> 16, lim);
  endfunction

  // Root of a sum of two 16-bit squares stays below 2^16.
  function automatic longint int_root(longint n);
    longint r;
    r = 0;
    for (longint b = 64'sd1 <<< 20; b > 0; b >>= 1)
      if ((r + b) * (r + b) <= n) r += b;
    return r;
  endfunction

  function automatic euler_t solve_euler(matrix_t m);
    euler_t e;
    longint a00, a10, sy;
    a00 = m.r00;
    a10 = m.r10;
    sy = int_root(a00 * a00 + a10 * a10);
    e.sing  = (sy < longint'(thr_shadow));
    e.pitch = 15'(vector_angle(-longint'(m.r20), sy, 12868));
    if (!e.sing) begin
      e.roll = 16'(vector_angle(m.r21, m.r22, 25736));
      e.yaw  = 16'(vector_angle(m.r10, m.r00, 25736));
    end else begin
      e.roll = 16'(vector_angle(-longint'(m.r12), m.r11, 25736));
      e.yaw  = '0;
    end
    return e;
  endfunction

  // Write the register while the pipe is empty; wait until the last beat
  // has left every stage, then idle before the write.
  task automatic load_threshold(int v);
    in_tvalid <= 1'b0;
    wait (angle_queue.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 11'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_shadow = 11'(v);
  endtask

  // Keep tvalid high between beats sent back to back; drop it only for a gap.
  task automatic send_matrix(matrix_t m, bit use_typed, euler_t typed);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    angle_queue.push_back(use_typed ? typed : solve_euler(m));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 65535));
      3: return 16'sd0;
      4: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
    matrix_t m;
    m.r00 = 16'(a); m.r10 = 16'(b); m.r11 = 16'(c); m.r12 = 16'(d);
    m.r20 = 16'(e); m.r21 = 16'(f); m.r22 = 16'(g);
    return m;
  endfunction

  function automatic euler_t ea(int r, int p, int y, bit s);
    euler_t e;
    e.roll = 16'(r); e.pitch = 15'(p); e.yaw = 16'(y); e.sing = s;
    return e;
  endfunction

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    euler_t exp_e;
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_queue.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_cnt++;
      end else begin
        exp_e = angle_queue.pop_front();
        if (out_tdata[15:0] !== exp_e.roll) begin
          $error("roll exp %0d got %0d", exp_e.roll, $signed(out_tdata[15:0]));
          fail_cnt++;
        end
        if (out_tdata[30:16] !== exp_e.pitch) begin
          $error("pitch exp %0d got %0d", exp_e.pitch, $signed(out_tdata[30:16]));
          fail_cnt++;
        end
        if (out_tdata[46:31] !== exp_e.yaw) begin
          $error("yaw exp %0d got %0d", exp_e.yaw, $signed(out_tdata[46:31]));
          fail_cnt++;
        end
        if (out_tuser !== exp_e.sing) begin
          $error("singular exp %0d got %0d", exp_e.sing, out_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // Result side backpressure: draw a stall length per beat, with calm stretches.
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready || !out_tready) begin
        w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side and no cfg write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= DOG_MAX) begin
      $display("rotation_matrix_to_euler_core regression: fail");
      $finish;
    end
  end

  row_t stim_table[$];

  initial begin
    euler_t none;
    matrix_t m;
    int thr_set[6];
    none = ea(0, 0, 0, 0);
    thr_set = '{0, 1024, 2047, 300, 1, 700};

    // Directed rows: identity, zero vector, extremes, gimbal lock, pre-rotation.
    stim_table.push_back('{mk(16384, 0, 16384, 0, 0, 0, 16384), -1, 1, ea(0, 0, 0, 0)});
    stim_table.push_back('{mk(0, 0, 0, 0, 0, 0, 0), -1, 1, ea(0, 0, 0, 1)});
    stim_table.push_back('{mk(0, 0, 16384, 0, -16384, 0, 16384), -1, 0, none});
    stim_table.push_back('{mk(0, 0, 16384, 0, 16384, 0, 16384), -1, 0, none});
    stim_table.push_back('{mk(-16384, 0, 16384, 0, 0, 0, -16384), -1, 0, none});
    stim_table.push_back('{mk(0, 16384, 0, 0, 0, 16384, 0), -1, 0, none});
    stim_table.push_back('{mk(0, -16384, 0, 0, 0, -16384, 0), -1, 0, none});
    stim_table.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768),
                          -1, 0, none});
    stim_table.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767),
                          -1, 0, none});
    stim_table.push_back('{mk(-32768, 0, -32768, 0, 0, 0, -32768), -1, 0, none});
    stim_table.push_back('{mk(10, 10, 16384, -16384, -16384, 5, 5), 2047, 0, none});
    stim_table.push_back('{mk(700, 700, -16384, 16384, 16384, 0, 0), -1, 0, none});
    stim_table.push_back('{mk(1000, 0, 0, 0, 0, 0, 0), -1, 0, none});
    stim_table.push_back('{mk(1024, 0, -5, 0, 0, 0, 0), 1024, 0, none});
    stim_table.push_back('{mk(1023, 0, -5, 0, 0, 0, 0), -1, 0, none});
    stim_table.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 0, 1, ea(0, 0, 0, 0)});
    stim_table.push_back('{mk(-1, 0, 0, 0, -1, -1, 0), -1, 0, none});
    stim_table.push_back('{mk(11585, 11585, 16384, 0, -11585, 11585, 11585), 1, 0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].thr >= 0) load_threshold(stim_table[i].thr);
      send_matrix(stim_table[i].m, stim_table[i].use_typed, stim_table[i].typed);
    end

    // Random phases, each under its own threshold.
    for (int ph = 0; ph < 6; ph++) begin
      load_threshold(thr_set[ph]);
      for (int k = 0; k < N_RAND / 6; k++) begin
        m.r00 = rand_elem(); m.r10 = rand_elem(); m.r11 = rand_elem();
        m.r12 = rand_elem(); m.r20 = rand_elem(); m.r21 = rand_elem();
        m.r22 = rand_elem();
        // Push some beats near gimbal lock.
        if ($urandom_range(0, 4) == 0) begin
          m.r00 = 16'(int'($urandom_range(0, 1400)) - 700);
          m.r10 = 16'(int'($urandom_range(0, 1400)) - 700);
        end
        send_matrix(m, 0, none);
      end
    end

    in_tvalid <= 1'b0;
    wait (angle_queue.size() == 0);
    repeat (60) @(posedge clk);
    if (fail_cnt == 0 && angle_queue.size() == 0)
      $display("rotation_matrix_to_euler_core regression: pass");
    else
      $display("rotation_matrix_to_euler_core regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rme_pkg.sv
hdl/rme_cordic.sv
hdl/rme_sqrt.sv
hdl/rotation_matrix_to_euler_core.sv
bench/tb_top.sv
